### src/obfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfd_pkg
// Shared widths, codes and transaction side data for the orthonormal basis
// datapath.
// ----------------------------------------------------------------------------
package obfd_pkg;

   localparam int COMP_BITS = 16;               // input direction component
   localparam int OUT_BITS  = 16;               // Q1.14 result component
   localparam int OPND_BITS = (COMP_BITS > OUT_BITS) ? COMP_BITS : OUT_BITS;
   localparam int OPND_W    = OPND_BITS + 1;    // cross product operand
   localparam int VEC_W     = 2 * OPND_W + 1;   // cross product result
   localparam int MAG_W     = 20;               // magnitude after alignment
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = 64;
   localparam int SQRT_STEPS = ROOT_W / 2;
   localparam int RES_W     = ROOT_W / 2;
   localparam int QUO_BITS  = 16;
   localparam int DIV_W     = 48;
   localparam int FRAC_SH   = 24;

   localparam int ONE_Q14      = 16384;
   localparam int NEAR_Z_LIMIT = 16056;         // 0.98 in Q1.14
   localparam int OUT_MAX      = 2 ** (OUT_BITS - 1) - 1;
   localparam int OUT_MIN      = -(2 ** (OUT_BITS - 1));

   localparam logic OP_USER = 1'b0;
   localparam logic OP_VIEW = 1'b1;

   localparam int                ADDR_W           = 3;
   localparam logic [ADDR_W-1:0] ADDR_MIRROR_LEFT = 3'd0;

   typedef struct packed {
      logic                             op;
      logic                             ok;
      logic [2:0][COMP_BITS-1:0]        dir;
      logic [2:0][OUT_BITS-1:0]         fwd;
      logic [2:0][OUT_BITS-1:0]         lft;
   } side_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  nz;
      side_type              side;
   } carry_type;

endpackage

### src/obfd_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfd_norm
// Pipelined 3-vector normalizer: align, sum of squares, one root bit per
// stage, one quotient bit per stage, round and clip to Q1.14.
// ----------------------------------------------------------------------------
module obfd_norm (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [2:0][obfd_pkg::VEC_W-1:0]        in_vec,
   input  obfd_pkg::side_type                     in_side,
   output logic                                   out_valid,
   output logic [2:0][obfd_pkg::OUT_BITS-1:0]     out_res,
   output logic                                   out_nz,
   output obfd_pkg::side_type                     out_side
);

   localparam int VW  = obfd_pkg::VEC_W;
   localparam int PW  = $clog2(VW);
   localparam int MW  = obfd_pkg::MAG_W;
   localparam int RW  = obfd_pkg::ROOT_W;
   localparam int NS  = obfd_pkg::SQRT_STEPS;
   localparam int QB  = obfd_pkg::QUO_BITS;
   localparam int DW  = obfd_pkg::DIV_W;
   localparam logic [PW-1:0] TOP_POS = PW'(MW - 1);
   localparam logic [QB-1:0] ONE_Q   = QB'(obfd_pkg::ONE_Q14);

   // stage A: magnitudes and largest
   logic [2:0][VW-1:0]  a_mag_in, a_mag_ff;
   logic [2:0]          a_neg_in, a_neg_ff;
   logic [VW-1:0]       a_max_in, a_max_ff;
   obfd_pkg::side_type  a_side_ff;
   logic                a_valid_ff;

   always_comb begin
      a_max_in = '0;
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = in_vec[i][VW-1];
         a_mag_in[i] = a_neg_in[i] ? (~in_vec[i] + 1'b1) : in_vec[i];
         if (a_mag_in[i] > a_max_in) begin
            a_max_in = a_mag_in[i];
         end
      end
   end

   // stage B: shift so that the largest lies in [2^19, 2^20)
   logic [PW-1:0]          b_lead;
   logic [2:0][VW-1:0]     b_sh;
   obfd_pkg::carry_type    b_carry_in, b_carry_ff;
   logic                   b_valid_ff;

   always_comb begin
      b_lead = '0;
      for (int i = 0; i < VW; i++) begin
         if (a_max_ff[i]) begin
            b_lead = PW'(i);
         end
      end
      b_carry_in      = '0;
      b_carry_in.nz   = |a_max_ff;
      b_carry_in.neg  = a_neg_ff;
      b_carry_in.side = a_side_ff;
      for (int i = 0; i < 3; i++) begin
         if (b_lead >= TOP_POS) begin
            b_sh[i] = a_mag_ff[i] >> (b_lead - TOP_POS);
         end else begin
            b_sh[i] = a_mag_ff[i] << (TOP_POS - b_lead);
         end
         b_carry_in.mag[i] = b_sh[i][MW-1:0];
      end
   end

   // stage C: squares
   logic [2:0][obfd_pkg::SQ_W-1:0] c_sq_in, c_sq_ff;
   obfd_pkg::carry_type            c_carry_ff;
   logic                           c_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_sq_in[i] = obfd_pkg::SQ_W'(b_carry_ff.mag[i]) * obfd_pkg::SQ_W'(b_carry_ff.mag[i]);
      end
   end

   // stage D and root pipeline
   logic [RW-1:0]        sr_rem_ff  [0:NS];
   logic [RW-1:0]        sr_root_ff [0:NS];
   obfd_pkg::carry_type  sr_carry_ff [0:NS];
   logic                 sr_valid_ff [0:NS];
   logic [RW-1:0]        sr_rem_in  [0:NS];
   logic [RW-1:0]        sr_root_in [0:NS];
   logic [obfd_pkg::SUM_W-1:0] d_sum;

   always_comb begin : root_steps
      logic [RW-1:0] bitv;
      logic [RW-1:0] trial;
      d_sum = obfd_pkg::SUM_W'(c_sq_ff[0]) + obfd_pkg::SUM_W'(c_sq_ff[1])
            + obfd_pkg::SUM_W'(c_sq_ff[2]);
      sr_rem_in[0]  = RW'(d_sum) << MW;
      sr_root_in[0] = '0;
      for (int k = 0; k < NS; k++) begin
         bitv  = RW'(1) << (RW - 2 - 2 * k);
         trial = sr_root_ff[k] + bitv;
         if (sr_rem_ff[k] >= trial) begin
            sr_rem_in[k+1]  = sr_rem_ff[k] - trial;
            sr_root_in[k+1] = (sr_root_ff[k] >> 1) + bitv;
         end else begin
            sr_rem_in[k+1]  = sr_rem_ff[k];
            sr_root_in[k+1] = sr_root_ff[k] >> 1;
         end
      end
   end

   // stage E and quotient pipeline
   logic [obfd_pkg::RES_W-1:0]  dv_div_ff [0:QB];
   logic [2:0][DW-1:0]          dv_rem_ff [0:QB];
   logic [2:0][QB-1:0]          dv_quo_ff [0:QB];
   obfd_pkg::carry_type         dv_carry_ff [0:QB];
   logic                        dv_valid_ff [0:QB];
   logic [2:0][DW-1:0]          dv_rem_in [0:QB];
   logic [2:0][QB-1:0]          dv_quo_in [0:QB];
   logic [obfd_pkg::RES_W-1:0]  e_root;

   always_comb begin : quo_steps
      logic [DW-1:0] sub;
      e_root = sr_root_ff[NS][obfd_pkg::RES_W-1:0];
      for (int i = 0; i < 3; i++) begin
         // rounding: add half the divisor
         dv_rem_in[0][i] = (DW'(sr_carry_ff[NS].mag[i]) << obfd_pkg::FRAC_SH)
                         + DW'(e_root >> 1);
         dv_quo_in[0][i] = '0;
      end
      for (int k = 0; k < QB; k++) begin
         sub = DW'(dv_div_ff[k]) << (QB - 1 - k);
         for (int i = 0; i < 3; i++) begin
            dv_quo_in[k+1][i] = dv_quo_ff[k][i];
            if (dv_rem_ff[k][i] >= sub) begin
               dv_rem_in[k+1][i]             = dv_rem_ff[k][i] - sub;
               dv_quo_in[k+1][i][QB - 1 - k] = 1'b1;
            end else begin
               dv_rem_in[k+1][i] = dv_rem_ff[k][i];
            end
         end
      end
   end

   // stage F: clip and sign
   logic [2:0][obfd_pkg::OUT_BITS-1:0] f_res_in, f_res_ff;
   logic [2:0][QB-1:0]                 f_clip;
   obfd_pkg::side_type                 f_side_ff;
   logic                               f_nz_ff;
   logic                               f_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_clip[i] = (dv_quo_ff[QB][i] > ONE_Q) ? ONE_Q : dv_quo_ff[QB][i];
         f_res_in[i] = dv_carry_ff[QB].neg[i]
                     ? obfd_pkg::OUT_BITS'(~f_clip[i] + 1'b1)
                     : obfd_pkg::OUT_BITS'(f_clip[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            sr_valid_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= QB; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         sr_valid_ff[0] <= c_valid_ff;
         for (int k = 0; k < NS; k++) begin
            sr_valid_ff[k+1] <= sr_valid_ff[k];
         end
         dv_valid_ff[0] <= sr_valid_ff[NS];
         for (int k = 0; k < QB; k++) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         f_valid_ff <= dv_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_max_ff  <= a_max_in;
         a_side_ff <= in_side;
         b_carry_ff <= b_carry_in;
         c_sq_ff    <= c_sq_in;
         c_carry_ff <= b_carry_ff;
         sr_rem_ff[0]   <= sr_rem_in[0];
         sr_root_ff[0]  <= sr_root_in[0];
         sr_carry_ff[0] <= c_carry_ff;
         for (int k = 0; k < NS; k++) begin
            sr_rem_ff[k+1]   <= sr_rem_in[k+1];
            sr_root_ff[k+1]  <= sr_root_in[k+1];
            sr_carry_ff[k+1] <= sr_carry_ff[k];
         end
         dv_div_ff[0]   <= e_root;
         dv_rem_ff[0]   <= dv_rem_in[0];
         dv_quo_ff[0]   <= dv_quo_in[0];
         dv_carry_ff[0] <= sr_carry_ff[NS];
         for (int k = 0; k < QB; k++) begin
            dv_div_ff[k+1]   <= dv_div_ff[k];
            dv_rem_ff[k+1]   <= dv_rem_in[k+1];
            dv_quo_ff[k+1]   <= dv_quo_in[k+1];
            dv_carry_ff[k+1] <= dv_carry_ff[k];
         end
         f_res_ff  <= f_res_in;
         f_nz_ff   <= dv_carry_ff[QB].nz;
         f_side_ff <= dv_carry_ff[QB].side;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_res   = f_res_ff;
   assign out_nz    = f_nz_ff;
   assign out_side  = f_side_ff;

endmodule

### src/orthonormal_basis_from_direction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_basis_from_direction_top
// Forward, left and up unit vectors (Q1.14) from a direction, user or view.
// ----------------------------------------------------------------------------
//  channel | handshake          | carries
//  req     | req_valid/ready    | operation, dir_x/y/z
//  rsp     | rsp_valid/ready    | forward, left, up, degenerate
//  csr     | psel/penable/pready| mirror_left at byte address 0
//
//  One transaction enters per cycle unless the output stalls. Pipeline:
//  three normalizers of 54 stages each (32 root stages, 16 quotient stages),
//  two 3-stage cross products, an input and an output register.
//  Synchronous reset clears valid bits and mirror_left.
//  The whole pipeline holds while a result waits on rsp_ready.
// ----------------------------------------------------------------------------
module orthonormal_basis_from_direction_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [obfd_pkg::ADDR_W-1:0]           paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [obfd_pkg::COMP_BITS-1:0] req_dir_x,
   input  logic signed [obfd_pkg::COMP_BITS-1:0] req_dir_y,
   input  logic signed [obfd_pkg::COMP_BITS-1:0] req_dir_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_forward_x,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_forward_y,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_forward_z,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_left_x,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_left_y,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_left_z,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_up_x,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_up_y,
   output logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_up_z,
   output logic                                  rsp_degenerate
);

   localparam int VW = obfd_pkg::VEC_W;
   localparam int OW = obfd_pkg::OPND_W;
   localparam int OB = obfd_pkg::OUT_BITS;
   localparam int AW = obfd_pkg::ADDR_W;

   logic en;
   logic mirror_ff;
   logic csr_hit;

   // ---------------- configuration ----------------
   assign pready  = 1'b1;
   assign csr_hit = (paddr[AW-1:2] == obfd_pkg::ADDR_MIRROR_LEFT[AW-1:2]);
   assign prdata  = csr_hit ? 32'(mirror_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         mirror_ff <= pwdata[0];
      end
   end

   // global advance: hold only when the output register is full and not taken
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- input register ----------------
   logic                 t0_valid_ff;
   logic [2:0][VW-1:0]   t0_vec_ff, t0_vec_in;
   obfd_pkg::side_type   t0_side_ff, t0_side_in;

   always_comb begin
      t0_side_in        = '0;
      t0_side_in.op     = req_operation;
      t0_side_in.ok     = 1'b1;
      t0_side_in.dir[0] = req_dir_x;
      t0_side_in.dir[1] = req_dir_y;
      t0_side_in.dir[2] = req_dir_z;
      t0_vec_in[0]      = VW'(req_dir_x);
      t0_vec_in[1]      = VW'(req_dir_y);
      t0_vec_in[2]      = VW'(req_dir_z);
   end

   // ---------------- normalizers ----------------
   logic                 n1_valid, n2_valid, n3_valid;
   logic [2:0][OB-1:0]   n1_res, n2_res, n3_res;
   logic                 n1_nz, n2_nz, n3_nz;
   obfd_pkg::side_type   n1_side, n2_side, n3_side;

   // cross product pipes: index 0 forms left, index 1 forms up
   logic [2:0][OW-1:0]     xa_in [0:1];
   logic [2:0][OW-1:0]     xb_in [0:1];
   obfd_pkg::side_type     xs_in [0:1];
   logic [2:0][OW-1:0]     xa_ff [0:1];
   logic [2:0][OW-1:0]     xb_ff [0:1];
   obfd_pkg::side_type     xs1_ff [0:1];
   logic                   xv1_ff [0:1];
   logic [5:0][2*OW-1:0]   xp_in [0:1];
   logic [5:0][2*OW-1:0]   xp_ff [0:1];
   obfd_pkg::side_type     xs2_ff [0:1];
   logic                   xv2_ff [0:1];
   logic [2:0][VW-1:0]     xc_in [0:1];
   logic [2:0][VW-1:0]     xc_ff [0:1];
   obfd_pkg::side_type     xs3_ff [0:1];
   logic                   xv3_ff [0:1];
   logic                   xv_in [0:1];

   obfd_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t0_valid_ff),
      .in_vec    (t0_vec_ff),
      .in_side   (t0_side_ff),
      .out_valid (n1_valid),
      .out_res   (n1_res),
      .out_nz    (n1_nz),
      .out_side  (n1_side)
   );

   obfd_norm u_norm_left (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xv3_ff[0]),
      .in_vec    (xc_ff[0]),
      .in_side   (xs3_ff[0]),
      .out_valid (n2_valid),
      .out_res   (n2_res),
      .out_nz    (n2_nz),
      .out_side  (n2_side)
   );

   obfd_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xv3_ff[1]),
      .in_vec    (xc_ff[1]),
      .in_side   (xs3_ff[1]),
      .out_valid (n3_valid),
      .out_res   (n3_res),
      .out_nz    (n3_nz),
      .out_side  (n3_side)
   );

   // ---------------- operand selection ----------------
   logic [OB:0]          fz_abs;
   logic                 near_z;
   logic [2:0][OW-1:0]   dir_w;

   always_comb begin
      fz_abs = n1_res[2][OB-1] ? (~{n1_res[2][OB-1], n1_res[2]} + 1'b1)
                               : {1'b0, n1_res[2]};
      near_z = (fz_abs > (OB + 1)'(obfd_pkg::NEAR_Z_LIMIT));
      for (int i = 0; i < 3; i++) begin
         dir_w[i] = OW'($signed(n1_side.dir[i]));
      end

      // left: forward x reference, or dir x Z in view mode
      xs_in[0] = n1_side;
      xv_in[0] = n1_valid;
      if (n1_side.op == obfd_pkg::OP_VIEW) begin
         xa_in[0]    = dir_w;
         xb_in[0][0] = '0;
         xb_in[0][1] = '0;
         xb_in[0][2] = OW'(1);
         xs_in[0].ok = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if ($signed(dir_w[i]) > $signed(OW'(obfd_pkg::OUT_MAX))) begin
               xs_in[0].fwd[i] = OB'(obfd_pkg::OUT_MAX);
            end else if ($signed(dir_w[i]) < $signed(OW'(obfd_pkg::OUT_MIN))) begin
               xs_in[0].fwd[i] = OB'(obfd_pkg::OUT_MIN);
            end else begin
               xs_in[0].fwd[i] = dir_w[i][OB-1:0];
            end
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            xa_in[0][i] = OW'($signed(n1_res[i]));
         end
         if (near_z) begin
            xb_in[0][0] = OW'($signed(n1_res[1]));
            xb_in[0][1] = OW'($signed(n1_res[2]));
            xb_in[0][2] = OW'($signed(n1_res[0]));
         end else begin
            xb_in[0][0] = '0;
            xb_in[0][1] = OW'(obfd_pkg::ONE_Q14);
            xb_in[0][2] = '0;
         end
         xs_in[0].ok  = n1_nz;
         xs_in[0].fwd = n1_res;
      end

      // up: left x forward, or left x dir in view mode
      xs_in[1]     = n2_side;
      xv_in[1]     = n2_valid;
      xs_in[1].ok  = n2_side.ok && n2_nz;
      xs_in[1].lft = n2_res;
      for (int i = 0; i < 3; i++) begin
         xa_in[1][i] = OW'($signed(n2_res[i]));
         if (n2_side.op == obfd_pkg::OP_VIEW) begin
            xb_in[1][i] = OW'($signed(n2_side.dir[i]));
         end else begin
            xb_in[1][i] = OW'($signed(n2_side.fwd[i]));
         end
      end
   end

   // products, then differences
   always_comb begin
      for (int g = 0; g < 2; g++) begin
         xp_in[g][0] = $signed(xa_ff[g][1]) * $signed(xb_ff[g][2]);
         xp_in[g][1] = $signed(xa_ff[g][2]) * $signed(xb_ff[g][1]);
         xp_in[g][2] = $signed(xa_ff[g][2]) * $signed(xb_ff[g][0]);
         xp_in[g][3] = $signed(xa_ff[g][0]) * $signed(xb_ff[g][2]);
         xp_in[g][4] = $signed(xa_ff[g][0]) * $signed(xb_ff[g][1]);
         xp_in[g][5] = $signed(xa_ff[g][1]) * $signed(xb_ff[g][0]);
         for (int i = 0; i < 3; i++) begin
            xc_in[g][i] = VW'($signed(xp_ff[g][2*i])) - VW'($signed(xp_ff[g][2*i+1]));
         end
      end
   end

   // ---------------- output ----------------
   logic                 out_ok;
   logic [2:0][OB-1:0]   rsp_fwd_ff, rsp_lft_ff, rsp_up_ff;
   logic [2:0][OB-1:0]   rsp_fwd_in, rsp_lft_in, rsp_up_in;
   logic                 rsp_degen_ff;

   always_comb begin
      out_ok = n3_side.ok && n3_nz;
      for (int i = 0; i < 3; i++) begin
         if (out_ok) begin
            rsp_fwd_in[i] = n3_side.fwd[i];
            rsp_lft_in[i] = mirror_ff ? (~n3_side.lft[i] + 1'b1) : n3_side.lft[i];
            rsp_up_in[i]  = n3_res[i];
         end else begin
            rsp_fwd_in[i] = '0;
            rsp_lft_in[i] = '0;
            rsp_up_in[i]  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < 2; g++) begin
            xv1_ff[g] <= 1'b0;
            xv2_ff[g] <= 1'b0;
            xv3_ff[g] <= 1'b0;
         end
      end else if (en) begin
         t0_valid_ff  <= req_valid;
         rsp_valid_ff <= n3_valid;
         for (int g = 0; g < 2; g++) begin
            xv1_ff[g] <= xv_in[g];
            xv2_ff[g] <= xv1_ff[g];
            xv3_ff[g] <= xv2_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_vec_ff  <= t0_vec_in;
         t0_side_ff <= t0_side_in;
         for (int g = 0; g < 2; g++) begin
            xa_ff[g]  <= xa_in[g];
            xb_ff[g]  <= xb_in[g];
            xs1_ff[g] <= xs_in[g];
            xp_ff[g]  <= xp_in[g];
            xs2_ff[g] <= xs1_ff[g];
            xc_ff[g]  <= xc_in[g];
            xs3_ff[g] <= xs2_ff[g];
         end
         rsp_fwd_ff   <= rsp_fwd_in;
         rsp_lft_ff   <= rsp_lft_in;
         rsp_up_ff    <= rsp_up_in;
         rsp_degen_ff <= !out_ok;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_forward_x  = rsp_fwd_ff[0];
   assign rsp_forward_y  = rsp_fwd_ff[1];
   assign rsp_forward_z  = rsp_fwd_ff[2];
   assign rsp_left_x     = rsp_lft_ff[0];
   assign rsp_left_y     = rsp_lft_ff[1];
   assign rsp_left_z     = rsp_lft_ff[2];
   assign rsp_up_x       = rsp_up_ff[0];
   assign rsp_up_y       = rsp_up_ff[1];
   assign rsp_up_z       = rsp_up_ff[2];
   assign rsp_degenerate = rsp_degen_ff;

endmodule

### src/obfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfd_checker
// Port-level checks on the basis block, bound to the top level.
// ----------------------------------------------------------------------------
module obfd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_forward_x,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_forward_y,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_forward_z,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_left_x,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_left_y,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_left_z,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_up_x,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_up_y,
   input logic signed [obfd_pkg::OUT_BITS-1:0]  rsp_up_z,
   input logic                                  rsp_degenerate
);

   localparam logic signed [obfd_pkg::OUT_BITS-1:0] ONE_P =
      obfd_pkg::OUT_BITS'(obfd_pkg::ONE_Q14);
   localparam logic signed [obfd_pkg::OUT_BITS-1:0] ONE_N =
      obfd_pkg::OUT_BITS'(-obfd_pkg::ONE_Q14);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_degenerate)
                                  && $stable(rsp_up_x) && $stable(rsp_left_x))
      else $error("stalled transaction changed");

   // input is held back only by a blocked output register
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without output back-pressure");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_forward_x == 0 && rsp_forward_y == 0 && rsp_forward_z == 0 &&
         rsp_left_x == 0 && rsp_left_y == 0 && rsp_left_z == 0 &&
         rsp_up_x == 0 && rsp_up_y == 0 && rsp_up_z == 0)
      else $error("degenerate transaction with non-zero vectors");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_up_x <= ONE_P && rsp_up_x >= ONE_N &&
         rsp_up_y <= ONE_P && rsp_up_y >= ONE_N &&
         rsp_up_z <= ONE_P && rsp_up_z >= ONE_N &&
         rsp_left_x <= ONE_P && rsp_left_x >= ONE_N &&
         rsp_left_y <= ONE_P && rsp_left_y >= ONE_N &&
         rsp_left_z <= ONE_P && rsp_left_z >= ONE_N)
      else $error("unit vector component out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind orthonormal_basis_from_direction_top obfd_checker u_obfd_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the orthonormal basis datapath. A directed table covers the axis
// directions, the zero vector, the near-Z fallback and the extreme components.
// Several hundred random directions follow, most of them drawn from
// magnitude-mixed distributions. Results are compared with a behavioural
// fixed-point predictor or a known table entry; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [15:0] fwd [3];
      logic [15:0] lft [3];
      logic [15:0] upv [3];
      logic        degen;
   } basis_type;

   typedef struct {
      logic        op;
      logic [15:0] x, y, z;
      logic        known;
      basis_type   res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [obfd_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic req_valid = 1'b0, req_ready, req_operation = 1'b0;
   logic signed [obfd_pkg::COMP_BITS-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic signed [obfd_pkg::OUT_BITS-1:0] rsp_forward_x, rsp_forward_y, rsp_forward_z;
   logic signed [obfd_pkg::OUT_BITS-1:0] rsp_left_x, rsp_left_y, rsp_left_z;
   logic signed [obfd_pkg::OUT_BITS-1:0] rsp_up_x, rsp_up_y, rsp_up_z;
   logic rsp_degenerate;

   basis_type basis_q [$];
   logic   mirror = 1'b0;
   int     n_err = 0;
   bit     stall_rsp = 1'b0;
   dir_row_type rows [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   orthonormal_basis_from_direction_top uut (.*);

   initial begin
      #20000000;
      $display("** orthonormal_basis_from_direction_top: FAILED **");
      $finish;
   end

   function automatic longint unsigned root64(longint unsigned t);
      longint unsigned acc = 0, b = 64'd1 << 62;
      while (b > t) b >>= 2;
      while (b != 0) begin
         if (t >= acc + b) begin
            t -= acc + b;
            acc = (acc >> 1) + b;
         end else begin
            acc >>= 1;
         end
         b >>= 2;
      end
      return acc;
   endfunction

   // unit vector in Q1.14; returns 0 for the zero vector
   function automatic bit unit_vec(input longint v [3], output longint o [3]);
      longint unsigned mg [3];
      longint unsigned top = 0, sq = 0, r, q;
      for (int i = 0; i < 3; i++) begin
         mg[i] = v[i] < 0 ? -v[i] : v[i];
         if (mg[i] > top) top = mg[i];
      end
      if (top == 0) return 0;
      while (top < (64'd1 << 19)) begin
         for (int i = 0; i < 3; i++) mg[i] <<= 1;
         top <<= 1;
      end
      while (top >= (64'd1 << 20)) begin
         for (int i = 0; i < 3; i++) mg[i] >>= 1;
         top >>= 1;
      end
      for (int i = 0; i < 3; i++) sq += mg[i] * mg[i];
      r = root64(sq << 20);
      for (int i = 0; i < 3; i++) begin
         q = ((mg[i] << 24) + (r >> 1)) / r;
         if (q > obfd_pkg::ONE_Q14) q = obfd_pkg::ONE_Q14;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic void cross3(input longint a [3], input longint b [3],
                                  output longint c [3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic basis_type predict_basis(logic op, logic [15:0] x, logic [15:0] y,
                                               logic [15:0] z, logic mir);
      longint d [3], f [3], rf [3], c [3], l [3], u [3];
      longint lv;
      bit ok;
      basis_type b;
      d[0] = longint'($signed(x));
      d[1] = longint'($signed(y));
      d[2] = longint'($signed(z));
      if (op == obfd_pkg::OP_USER) begin
         ok = unit_vec(d, f);
         if (ok) begin
            if ((f[2] < 0 ? -f[2] : f[2]) > obfd_pkg::NEAR_Z_LIMIT) begin
               rf[0] = f[1]; rf[1] = f[2]; rf[2] = f[0];
            end else begin
               rf[0] = 0; rf[1] = obfd_pkg::ONE_Q14; rf[2] = 0;
            end
            cross3(f, rf, c);
            ok = unit_vec(c, l);
         end
         if (ok) begin
            cross3(l, f, c);
            ok = unit_vec(c, u);
         end
      end else begin
         f = d;
         c[0] = d[1]; c[1] = -d[0]; c[2] = 0;
         ok = unit_vec(c, l);
         if (ok) begin
            cross3(l, d, c);
            ok = unit_vec(c, u);
         end
      end
      for (int i = 0; i < 3; i++) begin
         lv = mir ? -l[i] : l[i];
         b.fwd[i] = ok ? f[i][15:0] : '0;
         b.lft[i] = ok ? lv[15:0] : '0;
         b.upv[i] = ok ? u[i][15:0] : '0;
      end
      b.degen = !ok;
      return b;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
      n_err++;
   endtask

   // result side: random stalls and checking
   always @(posedge clock) begin
      basis_type e;
      logic [15:0] g [9];
      if (!reset) begin
         rsp_ready <= stall_rsp ? 1'b0 :
                      (($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0));
         if (rsp_valid && rsp_ready) begin
            if (basis_q.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_forward_x, 16'd0);
            end else begin
               e = basis_q.pop_front();
               g = '{rsp_forward_x, rsp_forward_y, rsp_forward_z, rsp_left_x,
                     rsp_left_y, rsp_left_z, rsp_up_x, rsp_up_y, rsp_up_z};
               for (int i = 0; i < 3; i++) begin
                  if (g[i] !== e.fwd[i]) report_mismatch("forward", g[i], e.fwd[i]);
                  if (g[3+i] !== e.lft[i]) report_mismatch("left", g[3+i], e.lft[i]);
                  if (g[6+i] !== e.upv[i]) report_mismatch("up", g[6+i], e.upv[i]);
               end
               if (rsp_degenerate !== e.degen)
                  report_mismatch("degenerate", 16'(rsp_degenerate), 16'(e.degen));
            end
         end
      end
   end

   task automatic csr_write(logic val);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= obfd_pkg::ADDR_MIRROR_LEFT;
      pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      mirror = val;
   endtask

   task automatic drain();
      while (basis_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_dir(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           bit known, basis_type want);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1; req_operation <= op;
      req_dir_x <= x; req_dir_y <= y; req_dir_z <= z;
      do @(posedge clock); while (!req_ready);
      basis_q.push_back(known ? want : predict_basis(op, x, y, z, mirror));
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($signed($urandom_range(0, 16)) - 8);
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         3: return 16'(int'($urandom_range(0, 511)) - 256);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic basis_type zero_basis();
      basis_type b;
      for (int i = 0; i < 3; i++) begin
         b.fwd[i] = '0; b.lft[i] = '0; b.upv[i] = '0;
      end
      b.degen = 1'b1;
      return b;
   endfunction

   initial begin
      dir_row_type r;
      basis_type nb;
      logic [15:0] x, y, z;
      nb = zero_basis();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero, axes, near-Z fallback, extremes
      rows = '{
         '{obfd_pkg::OP_USER, 16'h0000, 16'h0000, 16'h0000, 1'b1, nb},
         '{obfd_pkg::OP_VIEW, 16'h0000, 16'h0000, 16'h0000, 1'b1, nb},
         '{obfd_pkg::OP_VIEW, 16'h0000, 16'h0000, 16'h4000, 1'b1, nb},
         '{obfd_pkg::OP_USER, 16'h0000, 16'h4000, 16'h0000, 1'b1, nb},
         '{obfd_pkg::OP_USER, 16'h4000, 16'h0000, 16'h0000, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h0000, 16'h0000, 16'h4000, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h0000, 16'h0000, 16'hc000, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h0100, 16'h0200, 16'h4000, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h8000, 16'h8000, 16'h8000, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h0001, 16'hffff, 16'h0001, 1'b0, nb},
         '{obfd_pkg::OP_USER, 16'h8000, 16'h7fff, 16'h0000, 1'b0, nb},
         '{obfd_pkg::OP_VIEW, 16'h4000, 16'h0000, 16'h0000, 1'b0, nb},
         '{obfd_pkg::OP_VIEW, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, nb},
         '{obfd_pkg::OP_VIEW, 16'h8000, 16'h8000, 16'h8000, 1'b0, nb},
         '{obfd_pkg::OP_VIEW, 16'h0001, 16'h0000, 16'hffff, 1'b0, nb},
         '{obfd_pkg::OP_VIEW, 16'h1234, 16'hedcc, 16'h0000, 1'b0, nb},
         '{obfd_pkg::OP_VIEW, 16'h0000, 16'h0001, 16'h0000, 1'b0, nb}
      };

      for (int pass = 0; pass < 2; pass++) begin
         csr_write(pass[0]);
         foreach (rows[i]) begin
            r = rows[i];
            send_dir(r.op, r.x, r.y, r.z, r.known, r.res);
         end
         req_valid <= 1'b0;
         drain();
      end

      for (int n = 0; n < 600; n++) begin
         if (n % 150 == 0) begin
            req_valid <= 1'b0;
            drain();
            csr_write(1'($urandom_range(0, 1)));
         end
         if (n == 300) begin
            stall_rsp = 1'b1;
            repeat (60) @(posedge clock);
            stall_rsp = 1'b0;
         end
         x = rand_comp(); y = rand_comp(); z = rand_comp();
         if ($urandom_range(0, 15) == 0) begin
            x = 16'($urandom_range(0, 3)) - 16'd1; y = 16'($urandom_range(0, 3)) - 16'd1;
         end
         send_dir(1'($urandom_range(0, 1)), x, y, z, 1'b0, nb);
      end
      req_valid <= 1'b0;
      drain();
      if (n_err == 0)
         $display("** orthonormal_basis_from_direction_top: PASSED **");
      else
         $display("** orthonormal_basis_from_direction_top: FAILED **");
      $finish;
   end
endmodule
